// ===== hw/rtl/wsjq_pkg.sv =====
package wsjq_pkg;

   // Default build of the queue array
   localparam int DEF_NUM_WORKERS = 4;
   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int DEF_JOB_WIDTH   = 32;

   // Fixed field widths on the channels
   localparam int JOB_FIELD_W = 32;
   localparam int WID_FIELD_W = 2;

   typedef enum logic [0:0] {
      FUNC_PUSH  = 1'b0,
      FUNC_FETCH = 1'b1
   } func_type;

endpackage

// ===== hw/rtl/wsjq_if.sv =====
interface wsjq_req_if;
   import wsjq_pkg::*;

   logic                   valid;
   logic                   ready;
   func_type               func;
   logic [WID_FIELD_W-1:0] worker_id;
   logic [JOB_FIELD_W-1:0] job_word;

   modport source (output valid, func, worker_id, job_word, input ready);
   modport sink   (input valid, func, worker_id, job_word, output ready);
endinterface

interface wsjq_rsp_if;
   import wsjq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [JOB_FIELD_W-1:0] job_out;
   logic                   found;
   logic [WID_FIELD_W-1:0] source_worker;
   logic                   stolen;
   logic                   overflow;

   modport source (output valid, job_out, found, source_worker, stolen, overflow,
                   input ready);
   modport sink   (input valid, job_out, found, source_worker, stolen, overflow,
                   output ready);
endinterface

// ===== hw/rtl/work_stealing_job_queues_top.sv =====
// Each request word passes through stage 1 (the job RAM read) and then the output
// register before its result word is offered on the result side.
// Throughput: one push or fetch per cycle while the result side keeps up; a stalled
// result word blocks new requests once two words are in flight.
// Deque state moves at the accept edge, so a following word sees it at once.
// Reset (synchronous, active high) empties every deque and drops words in flight;
// the job RAM is not cleared, its slots are only read after being written.
module work_stealing_job_queues_top #(
   parameter int NUM_WORKERS = wsjq_pkg::DEF_NUM_WORKERS,
   parameter int QUEUE_DEPTH = wsjq_pkg::DEF_QUEUE_DEPTH,
   parameter int JOB_WIDTH   = wsjq_pkg::DEF_JOB_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   wsjq_req_if.sink   req_if,
   wsjq_rsp_if.source rsp_if
);
   import wsjq_pkg::*;

   localparam int WK_W   = $clog2(NUM_WORKERS);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS  = NUM_WORKERS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);

   // Per-worker deque bookkeeping
   logic [PTR_W-1:0] head_ff [NUM_WORKERS];
   logic [PTR_W-1:0] tail_ff [NUM_WORKERS];
   logic [OCC_W-1:0] occ_ff  [NUM_WORKERS];

   // Stage 1: RAM read in flight, result flags waiting for the data
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_found_ff;
   logic [WID_FIELD_W-1:0] s1_src_ff;
   logic                   s1_stolen_ff;
   logic                   s1_ovf_ff;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [JOB_FIELD_W-1:0] rsp_job_ff;
   logic                   rsp_found_ff;
   logic [WID_FIELD_W-1:0] rsp_src_ff;
   logic                   rsp_stolen_ff;
   logic                   rsp_ovf_ff;

   logic req_accept;
   logic s1_move;

   // Decode of the current request
   logic              own_ok;
   logic [WK_W-1:0]   own_idx;
   logic              own_full;
   logic              own_nonempty;
   logic              do_push;
   logic              do_pop;
   logic              do_steal;
   logic              ovf;
   logic              any_nonempty;
   logic [WK_W-1:0]   victim;
   logic [PTR_W-1:0]  tail_dec;
   logic [PTR_W-1:0]  tail_inc;
   logic [PTR_W-1:0]  head_inc;

   // RAM port signals
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [JOB_WIDTH-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [JOB_WIDTH-1:0] ram_rd_data;
   logic [JOB_FIELD_W-1:0] rd_job;

   // ---------------------------------------------------------------------
   // Handshake: stage 1 drains into the output register when that is free
   // or being taken; a new word enters only when stage 1 can move on.
   // ---------------------------------------------------------------------
   assign s1_move    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || s1_move;
   assign req_accept = req_if.valid && req_if.ready;

   // ---------------------------------------------------------------------
   // Request decode against the deque state
   // ---------------------------------------------------------------------
   always_comb begin
      own_ok       = 32'(req_if.worker_id) < NUM_WORKERS;
      own_idx      = WK_W'(req_if.worker_id);
      own_full     = own_ok && (occ_ff[own_idx] == OCC_W'(QUEUE_DEPTH));
      own_nonempty = own_ok && (occ_ff[own_idx] != '0);

      // lowest-numbered non-empty deque; own deque is empty whenever this is used
      any_nonempty = 1'b0;
      victim       = '0;
      for (int v = NUM_WORKERS - 1; v >= 0; v--) begin
         if (occ_ff[v] != '0) begin
            any_nonempty = 1'b1;
            victim       = WK_W'(v);
         end
      end

      do_push  = 1'b0;
      do_pop   = 1'b0;
      do_steal = 1'b0;
      ovf      = 1'b0;
      unique case (req_if.func)
         FUNC_PUSH: begin
            ovf     = own_full;
            do_push = own_ok && !own_full;
         end
         FUNC_FETCH: begin
            do_pop   = own_nonempty;
            do_steal = !own_nonempty && any_nonempty;
         end
         default: begin
            ovf = 1'b0;
         end
      endcase

      tail_inc = (tail_ff[own_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                 : tail_ff[own_idx] + PTR_W'(1);
      tail_dec = (tail_ff[own_idx] == '0) ? PTR_W'(QUEUE_DEPTH - 1)
                 : tail_ff[own_idx] - PTR_W'(1);
      head_inc = (head_ff[victim] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                 : head_ff[victim] + PTR_W'(1);
   end

   // ---------------------------------------------------------------------
   // Job RAM access: write at the tail on push, read the new tail on a
   // local pop, read the victim's head on a steal.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < JOB_WIDTH; i++) begin
         ram_wr_data[i] = (i < JOB_FIELD_W) ? req_if.job_word[i] : 1'b0;
      end
      ram_wr_en   = req_accept && do_push;
      ram_wr_addr = ADDR_W'(own_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_ff[own_idx]);
      ram_rd_en   = req_accept && (do_pop || do_steal);
      if (do_pop) begin
         ram_rd_addr = ADDR_W'(own_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_dec);
      end else begin
         ram_rd_addr = ADDR_W'(victim) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[victim]);
      end
   end

   wsjq_job_ram #(
      .DEPTH  (SLOTS),
      .DATA_W (JOB_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Fit the stored job to the 32-bit result field
   always_comb begin
      for (int i = 0; i < JOB_FIELD_W; i++) begin
         rd_job[i] = (i < JOB_WIDTH) ? ram_rd_data[i] : 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Deque pointers and fill counts: advance at the accept edge
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WORKERS; w++) begin
            head_ff[w] <= '0;
            tail_ff[w] <= '0;
            occ_ff[w]  <= '0;
         end
      end else if (req_accept) begin
         if (do_push) begin
            tail_ff[own_idx] <= tail_inc;
            occ_ff[own_idx]  <= occ_ff[own_idx] + OCC_W'(1);
         end
         if (do_pop) begin
            tail_ff[own_idx] <= tail_dec;
            occ_ff[own_idx]  <= occ_ff[own_idx] - OCC_W'(1);
         end
         if (do_steal) begin
            head_ff[victim] <= head_inc;
            occ_ff[victim]  <= occ_ff[victim] - OCC_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1 and output register
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_valid_ff && s1_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // flags ride along with the RAM read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_found_ff  <= do_pop || do_steal;
         s1_stolen_ff <= do_steal;
         s1_ovf_ff    <= ovf;
         if (do_pop) begin
            s1_src_ff <= WID_FIELD_W'(own_idx);
         end else if (do_steal) begin
            s1_src_ff <= WID_FIELD_W'(victim);
         end else begin
            s1_src_ff <= '0;
         end
      end
   end

   // zero the job field unless a job was found
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_move) begin
         rsp_job_ff    <= s1_found_ff ? rd_job : '0;
         rsp_found_ff  <= s1_found_ff;
         rsp_src_ff    <= s1_src_ff;
         rsp_stolen_ff <= s1_stolen_ff;
         rsp_ovf_ff    <= s1_ovf_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.job_out       = rsp_job_ff;
   assign rsp_if.found         = rsp_found_ff;
   assign rsp_if.source_worker = rsp_src_ff;
   assign rsp_if.stolen        = rsp_stolen_ff;
   assign rsp_if.overflow      = rsp_ovf_ff;

endmodule

// ===== hw/rtl/wsjq_job_ram.sv =====
module wsjq_job_ram #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
